// ===== rtl/stid_pkg.sv =====
package stid_pkg;

   // Table geometry
   localparam int SLOTS   = 16;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int POS_W   = 4;
   localparam int KEY_W   = 44;
   localparam int PRICE_W = 16;
   localparam int SIDX_W  = 4;
   localparam int CMP_W   = (IDX_W > POS_W) ? IDX_W : POS_W;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [PRICE_W-1:0] price;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic             load;
      logic             step;
      logic [IDX_W-1:0] idx;
      logic             last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/stid_ctrl.sv =====
module stid_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stid_pkg::status_type status,
   output stid_pkg::cmd_type    cmd
);

   stid_pkg::state_type state_ff, state_in;
   logic [stid_pkg::IDX_W-1:0] count_ff, count_in;
   logic last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stid_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign last_idx = (count_ff == stid_pkg::IDX_W'(stid_pkg::SLOTS - 1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      req_stall = 1'b1;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      cmd.idx   = count_ff;
      cmd.last  = last_idx;
      unique case (state_ff)
         stid_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = stid_pkg::ST_RUN;
            end
         end
         stid_pkg::ST_RUN: begin
            // advance one slot whenever the output register can take it
            if (status.out_free) begin
               cmd.step = 1'b1;
               count_in = count_ff + 1'b1;
               if (last_idx) begin
                  count_in = '0;
                  state_in = stid_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = stid_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/stid_datapath.sv =====
module stid_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  stid_pkg::cmd_type              cmd,
   output stid_pkg::status_type           status,
   input  logic                           req_operation,
   input  logic [stid_pkg::POS_W-1:0]     req_position,
   input  logic [stid_pkg::KEY_W-1:0]     req_book_key,
   input  logic [stid_pkg::PRICE_W-1:0]   req_book_price,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [stid_pkg::SIDX_W-1:0]    rsp_slot_index,
   output logic [stid_pkg::KEY_W-1:0]     rsp_slot_key,
   output logic [stid_pkg::PRICE_W-1:0]   rsp_slot_price,
   output logic                           rsp_last_slot
);

   // Ring of slots: head is the slot being streamed, new values enter at the tail
   stid_pkg::entry_type ring_ff [stid_pkg::SLOTS];
   stid_pkg::entry_type carry_ff;
   stid_pkg::entry_type new_entry;

   stid_pkg::op_type                 op_ff;
   logic [stid_pkg::POS_W-1:0]       pos_ff;
   logic [stid_pkg::KEY_W-1:0]       key_ff;
   logic [stid_pkg::PRICE_W-1:0]     price_ff;
   logic                             hit_ff, hit_in;

   logic                             rsp_valid_ff;
   logic [stid_pkg::SIDX_W-1:0]      slot_index_ff;
   stid_pkg::entry_type              slot_ff;
   logic                             last_slot_ff;

   logic [stid_pkg::CMP_W-1:0]       idx_ext, pos_ext;
   logic                             match_now;

   assign idx_ext   = stid_pkg::CMP_W'(cmd.idx);
   assign pos_ext   = stid_pkg::CMP_W'(pos_ff);
   assign match_now = (ring_ff[0].key == key_ff);
   assign hit_in    = hit_ff | match_now;

   always_comb begin
      new_entry = ring_ff[0];
      case (op_ff)
         stid_pkg::OP_INSERT: begin
            if (idx_ext == pos_ext) begin
               new_entry.key   = key_ff;
               new_entry.price = price_ff;
            end else if (idx_ext > pos_ext) begin
               new_entry = carry_ff;
            end
         end
         stid_pkg::OP_DELETE: begin
            // pull the next slot down once the match has been seen; clear the last
            if (hit_in) begin
               new_entry = cmd.last ? '0 : ring_ff[1];
            end
         end
         default: begin
            new_entry = ring_ff[0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < stid_pkg::SLOTS; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (cmd.step) begin
         for (int i = 0; i < stid_pkg::SLOTS - 1; i++) begin
            ring_ff[i] <= ring_ff[i+1];
         end
         ring_ff[stid_pkg::SLOTS-1] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= stid_pkg::op_type'(req_operation);
         pos_ff   <= req_position;
         key_ff   <= req_book_key;
         price_ff <= req_book_price;
      end
      if (cmd.step) begin
         carry_ff <= ring_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff <= 1'b0;
      end else if (cmd.step) begin
         hit_ff <= hit_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         slot_index_ff <= stid_pkg::SIDX_W'(cmd.idx);
         slot_ff       <= new_entry;
         last_slot_ff  <= cmd.last;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = slot_index_ff;
   assign rsp_slot_key   = slot_ff.key;
   assign rsp_slot_price = slot_ff.price;
   assign rsp_last_slot  = last_slot_ff;

endmodule

// ===== rtl/shift_table_insert_delete_top.sv =====
// Shift table with insert and delete.
//
// Request channel (req_valid / req_stall): operation selects insert at
// req_position or delete of the lowest slot whose key equals req_book_key.
// An insert pushes later slots up and drops the last one; a delete pulls
// later slots down and clears the last slot. A missed delete changes nothing.
//
// Response channel (rsp_valid / rsp_stall): after each request the whole
// table comes out, one response per slot, slot 0 first, rsp_last_slot high
// on the final slot.
//
// Throughput: a request is registered on acceptance; the slots leave through
// the output register, one slot per cycle unless rsp_stall holds it. The
// slots sit in a register ring that rotates one place per cycle when not
// stalled, updating the entry at its head as it streams out. The next request
// is accepted while the last slot still waits to be taken.
//
// Reset clears every slot to zero. A stall on the response side freezes the
// ring and holds the waiting response; request stall stays high until the
// rotation finishes.
module shift_table_insert_delete_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [stid_pkg::POS_W-1:0]     req_position,
   input  logic [stid_pkg::KEY_W-1:0]     req_book_key,
   input  logic [stid_pkg::PRICE_W-1:0]   req_book_price,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [stid_pkg::SIDX_W-1:0]    rsp_slot_index,
   output logic [stid_pkg::KEY_W-1:0]     rsp_slot_key,
   output logic [stid_pkg::PRICE_W-1:0]   rsp_slot_price,
   output logic                           rsp_last_slot
);

   stid_pkg::cmd_type    cmd;
   stid_pkg::status_type status;

   // Sequence the rotation: capture the request, then step once per slot
   stid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the table, apply the update at the ring head, drive the output register
   stid_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_position   (req_position),
      .req_book_key   (req_book_key),
      .req_book_price (req_book_price),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_slot_key   (rsp_slot_key),
      .rsp_slot_price (rsp_slot_price),
      .rsp_last_slot  (rsp_last_slot)
   );

endmodule
